// ===== rtl/pcicfg_pkg.sv =====
// package with shared types, codes and constants of the pci config space emulator
`timescale 1ns / 1ps

package pcicfg_pkg;

    // store geometry: four byte lanes, one bank per lane
    localparam int SPACE_BYTES = 256;
    localparam int NUM_BANKS   = 4;
    localparam int BANK_ROWS   = SPACE_BYTES / NUM_BANKS;
    localparam int ROW_W       = $clog2(BANK_ROWS);

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 3;
    localparam logic [2:0]  REG_VENDOR_ID      = 3'd0;
    localparam logic [2:0]  REG_DEVICE_ID      = 3'd1;
    localparam logic [2:0]  REG_CLASS_REVISION = 3'd2;
    localparam logic [2:0]  REG_BAR0_BASE      = 3'd3;
    localparam logic [2:0]  REG_BAR0_LENGTH    = 3'd4;

    // configuration reset values
    localparam logic [15:0] VENDOR_ID_RST      = 16'h1414;
    localparam logic [15:0] DEVICE_ID_RST      = 16'h5353;
    localparam logic [31:0] CLASS_REVISION_RST = 32'h0300_0000;
    localparam logic [31:0] BAR0_BASE_RST      = 32'h0000_0000;
    localparam logic [31:0] BAR0_LENGTH_RST    = 32'h0080_0000;

    // header offsets
    localparam logic [7:0] OFS_BAR0 = 8'h10;
    localparam logic [7:0] OFS_BAR5 = 8'h24;
    localparam logic [7:0] OFS_ROM  = 8'h30;

    // dword rows held in flops so that a load can fill them all at once
    localparam int                IDENT_ROWS = 4;
    localparam logic [ROW_W-1:0]  ROW_ID     = ROW_W'(8'h00 >> 2);
    localparam logic [ROW_W-1:0]  ROW_CLASS  = ROW_W'(8'h08 >> 2);
    localparam logic [ROW_W-1:0]  ROW_BAR0   = ROW_W'(8'h10 >> 2);
    localparam logic [ROW_W-1:0]  ROW_SUBSYS = ROW_W'(8'h2C >> 2);
    localparam logic [1:0]        SLOT_ID     = 2'd0;
    localparam logic [1:0]        SLOT_CLASS  = 2'd1;
    localparam logic [1:0]        SLOT_BAR0   = 2'd2;
    localparam logic [1:0]        SLOT_SUBSYS = 2'd3;

    // request and result payloads
    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  device_num;
        logic [2:0]  function_num;
        logic [7:0]  byte_offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } pcicfg_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        matched;
    } pcicfg_result_t;

    // value mask for an access size; unused code acts as a dword
    function automatic logic [31:0] size_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // number of bytes touched minus one
    function automatic logic [1:0] size_last_lane(input logic [1:0] size);
        logic [1:0] n;
        case (size)
            SIZE_BYTE: n = 2'd0;
            SIZE_HALF: n = 2'd1;
            default:   n = 2'd3;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/pci_config_space_emulator_top.sv =====
// top level of the type-0 pci config space emulator for device 0 function 0
`timescale 1ns / 1ps

// channel  | signals                          | handshake
// ---------+----------------------------------+---------------------------------
// request  | start, busy, req                 | taken at an edge with start & !busy
// result   | result_valid, result             | one-cycle strobe, no back pressure
// config   | cfg_wr_en, cfg_index, cfg_wdata  | written at an edge with cfg_wr_en
//
// one request per cycle; busy is never raised
// a read or write gives its result in the cycle after the request edge
// a load or unused command updates state and gives no result
// the store reads as zero after reset, no clearing pass needed
// latency is set by the registered read of the four byte-lane banks

module pci_config_space_emulator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pcicfg_pkg::pcicfg_req_t        req,
    output logic                           result_valid,
    output pcicfg_pkg::pcicfg_result_t     result,
    input  logic                           cfg_wr_en,
    input  logic [pcicfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata
);
    import pcicfg_pkg::*;

    // configuration registers
    logic [15:0] vendor_id_reg;
    logic [15:0] device_id_reg;
    logic [31:0] class_revision_reg;
    logic [31:0] bar0_base_reg;
    logic [31:0] bar0_length_reg;

    // identity rows held in flops
    logic [IDENT_ROWS-1:0][NUM_BANKS-1:0][7:0] ident_reg;
    logic [IDENT_ROWS-1:0][NUM_BANKS-1:0][7:0] ident_next;

    // request decode
    logic        accept;
    logic        hit;
    logic        is_load;
    logic        wr_ok;
    logic        sizing;
    logic [31:0] wr_value;
    logic [1:0]  ofs_lo;
    logic [ROW_W-1:0] ofs_row;
    logic [1:0]  last_lane;

    // per-bank ports
    logic [NUM_BANKS-1:0]            bank_wen;
    logic [NUM_BANKS-1:0][ROW_W-1:0] bank_row;
    logic [NUM_BANKS-1:0][7:0]       bank_wbyte;
    logic [NUM_BANKS-1:0][7:0]       bank_rbyte;
    logic [NUM_BANKS-1:0]            bank_in_ident;
    logic [NUM_BANKS-1:0][1:0]       bank_slot;

    // result stage
    logic                      res_valid_reg;
    logic                      is_read_reg;
    logic                      hit_reg;
    logic [1:0]                size_reg;
    logic [1:0]                lo_reg;
    logic [NUM_BANKS-1:0]      flop_sel_reg;
    logic [NUM_BANKS-1:0][7:0] flop_byte_reg;
    logic [NUM_BANKS-1:0][7:0] lane_byte;
    logic [31:0]               raw_data;
    logic [31:0]               out_mask;

    // which identity flop row a bank row maps to
    function automatic logic [2:0] ident_lookup(input logic [ROW_W-1:0] row);
        logic [2:0] r;
        case (row)
            ROW_ID:     r = {1'b1, SLOT_ID};
            ROW_CLASS:  r = {1'b1, SLOT_CLASS};
            ROW_BAR0:   r = {1'b1, SLOT_BAR0};
            ROW_SUBSYS: r = {1'b1, SLOT_SUBSYS};
            default:    r = 3'b000;
        endcase
        return r;
    endfunction

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign hit     = (req.device_num == 5'd0) && (req.function_num == 3'd0);
    assign is_load = accept && (req.command == CMD_LOAD);
    assign ofs_lo  = req.byte_offset[1:0];
    assign ofs_row = req.byte_offset[7:2];
    assign last_lane = size_last_lane(req.access_size);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_id_reg      <= VENDOR_ID_RST;
            device_id_reg      <= DEVICE_ID_RST;
            class_revision_reg <= CLASS_REVISION_RST;
            bar0_base_reg      <= BAR0_BASE_RST;
            bar0_length_reg    <= BAR0_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_VENDOR_ID:      vendor_id_reg      <= cfg_wdata[15:0];
                REG_DEVICE_ID:      device_id_reg      <= cfg_wdata[15:0];
                REG_CLASS_REVISION: class_revision_reg <= cfg_wdata;
                REG_BAR0_BASE:      bar0_base_reg      <= cfg_wdata;
                REG_BAR0_LENGTH:    bar0_length_reg    <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // write filter: rom base, bar1..bar5, narrow bar0 writes are dropped
    always_comb
    begin
        wr_ok = accept && (req.command == CMD_WRITE) && hit
                && (req.byte_offset != OFS_ROM);
        if (req.access_size[1])
        begin
            if ((req.byte_offset > OFS_BAR0) && (req.byte_offset <= OFS_BAR5))
            begin
                wr_ok = 1'b0;
            end
        end
        else if ((req.byte_offset >= OFS_BAR0) && (req.byte_offset <= OFS_BAR5))
        begin
            wr_ok = 1'b0;
        end
        sizing   = req.access_size[1] && (req.byte_offset == OFS_BAR0)
                   && (req.write_data == 32'hFFFF_FFFF);
        wr_value = sizing ? (~bar0_length_reg + 32'd1) : req.write_data;
    end

    // steer the request bytes onto the four bank lanes
    always_comb
    begin
        logic [1:0] lane;
        logic [2:0] sel;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            lane          = 2'(b) - ofs_lo;
            bank_row[b]   = ofs_row + ROW_W'(2'(b) < ofs_lo);
            bank_wen[b]   = wr_ok && (lane <= last_lane);
            bank_wbyte[b] = wr_value[8*lane +: 8];
            sel              = ident_lookup(bank_row[b]);
            bank_in_ident[b] = sel[2];
            bank_slot[b]     = sel[1:0];
        end
    end

    // byte-lane banks
    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        pcicfg_bank u_bank (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (bank_wen[g]),
            .wr_row  (bank_row[g]),
            .wr_byte (bank_wbyte[g]),
            .rd_en   (accept),
            .rd_row  (bank_row[g]),
            .rd_byte (bank_rbyte[g])
        );
    end

    // identity rows: load fills them, ordinary writes patch bytes
    always_comb
    begin
        ident_next = ident_reg;
        if (is_load)
        begin
            ident_next[SLOT_ID]     = {device_id_reg, vendor_id_reg};
            ident_next[SLOT_CLASS]  = class_revision_reg;
            ident_next[SLOT_BAR0]   = bar0_base_reg;
            ident_next[SLOT_SUBSYS] = {device_id_reg, vendor_id_reg};
        end
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (bank_wen[b] && bank_in_ident[b])
            begin
                ident_next[bank_slot[b]][b] = bank_wbyte[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= '0;
        end
        else
        begin
            ident_reg <= ident_next;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            is_read_reg   <= 1'b0;
            flop_sel_reg  <= '0;
        end
        else
        begin
            res_valid_reg <= accept && ((req.command == CMD_READ)
                                        || (req.command == CMD_WRITE));
            if (accept)
            begin
                is_read_reg  <= (req.command == CMD_READ);
                flop_sel_reg <= bank_in_ident;
            end
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg  <= hit;
            size_reg <= req.access_size;
            lo_reg   <= ofs_lo;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                flop_byte_reg[b] <= ident_reg[bank_slot[b]][b];
            end
        end
    end

    // gather bytes little-endian from the start lane
    always_comb
    begin
        logic [1:0] bank;
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            bank         = lo_reg + 2'(i);
            lane_byte[i] = flop_sel_reg[bank] ? flop_byte_reg[bank] : bank_rbyte[bank];
        end
        raw_data = lane_byte;
        out_mask = size_mask(size_reg);
    end

    assign result_valid     = res_valid_reg;
    assign result.matched   = hit_reg;
    assign result.read_data = !is_read_reg ? 32'h0000_0000 :
                              hit_reg      ? (raw_data & out_mask) : out_mask;

`ifndef ASSERT_OFF
    // every result follows a request edge
    a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept))
        else $error("result without a request");

    // a load gives no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> !result_valid)
        else $error("load produced a result");

    // write results carry zero data
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_read_reg) |-> (result.read_data == 32'h0000_0000))
        else $error("write result with nonzero data");

    // unmatched reads return all ones at the access width
    a_miss_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_read_reg && !result.matched)
        |-> (result.read_data == size_mask(size_reg)))
        else $error("unmatched read not all ones");

    // a load puts the configured base into bar0
    a_load_bar0: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> (ident_reg[SLOT_BAR0] == $past(bar0_base_reg)))
        else $error("bar0 not loaded from base");
`endif

endmodule

// ===== rtl/pcicfg_bank.sv =====
// one byte-lane bank of the config store with per-row valid bits and registered read
`timescale 1ns / 1ps

module pcicfg_bank (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [pcicfg_pkg::ROW_W-1:0] wr_row,
    input  logic [7:0]                 wr_byte,
    input  logic                       rd_en,
    input  logic [pcicfg_pkg::ROW_W-1:0] rd_row,
    output logic [7:0]                 rd_byte
);
    import pcicfg_pkg::*;

    logic [7:0]           store_reg [BANK_ROWS];
    logic [BANK_ROWS-1:0] valid_reg;
    logic [BANK_ROWS-1:0] valid_next;
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;

    // byte array write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_row] <= wr_byte;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_row];
        end
    end

    // a row reads as zero until first written
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_row];
            end
        end
    end

    assign rd_byte = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule
